// ===== rtl/core/hpr_pkg.sv =====
// shared constants, types and tables for the heading/pitch/roll rotation matrix unit
`timescale 1ns / 1ps
`default_nettype none
package hpr_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int TRIG_ITERATIONS = 16;

    localparam int ANGLE_W = 17;
    localparam int OUT_W   = 16;
    localparam int Q_W     = 32;   // q30 datapath width

    // angle reduction: modulus of one turn and a bias that makes every input nonnegative
    localparam longint ANG_MOD = longint'(360) << ANGLE_FRAC_BITS;
    localparam longint ANG_OFS = ((longint'(65536) + ANG_MOD - 1) / ANG_MOD) * ANG_MOD;
    localparam int     U_W     = $clog2(longint'(65536) + ANG_OFS);
    localparam int     M_W     = $clog2(ANG_MOD + 1);
    localparam int     RQS     = U_W + M_W + 1;
    localparam longint RQ      = (longint'(1) << RQS) / ANG_MOD;
    localparam int     RQ_W    = $clog2(RQ + 1);
    localparam int     A_W     = $clog2(ANG_MOD);

    // one turn is 45 * 2^(ANGLE_FRAC_BITS+3): split a residue into a multiple of 45 and the rest
    localparam int     K_W  = ANGLE_FRAC_BITS + 3;
    localparam int     RKS  = A_W + 6;
    localparam longint RK   = ((longint'(1) << RKS) / 45) + 1;
    localparam int     RK_W = $clog2(RK + 1);
    localparam int     PSH  = 29 - ANGLE_FRAC_BITS;
    localparam int     R_W  = 6;

    localparam logic signed [Q_W-1:0] GAIN_Q30 = 32'sd652032874;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef angle_t [2:0]              angle3_t;
    typedef logic [31:0]               phase_t;
    typedef phase_t [2:0]              phase3_t;
    typedef logic signed [Q_W-1:0]     q30_t;
    typedef logic signed [OUT_W-1:0]   entry_t;
    typedef entry_t [8:0]              matrix_t;   // m00 m10 m20 m01 m11 m21 m02 m12 m22

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sincos_t;
    typedef sincos_t [2:0] sincos3_t;

    typedef logic [PSH-1:0] frac_tab_t [45];

    // fraction of a phase for residues 0..44, rounded half up
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t t;
        for (int r = 0; r < 45; r++)
        begin
            t[r] = PSH'(((longint'(r) << PSH) + 22) / 45);
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage
`default_nettype wire

// ===== rtl/core/hpr_angles_to_rotation_matrix_unit.sv =====
// top level: heading/pitch/roll angles in, 3x3 rotation matrix out
//
// input stream s_axis carries one item of three angles (signed degrees, 7 fraction
// bits); output stream m_axis carries the nine matrix entries as signed q2.14,
// saturated to plus or minus one. one result item for each input item, in order.
// the datapath is a single pipeline: 4 stages of angle reduction, 18 stages of
// cordic (quadrant fold, 16 iterations, quadrant map) and 3 stages of products
// and output rounding. throughput is one item per cycle unless the output stalls;
// every stage holds one item.
// when the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// reset clears all valid bits; no other state is kept between items.
`timescale 1ns / 1ps
`default_nettype none
module hpr_angles_to_rotation_matrix_unit (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [55:0]  s_axis_tdata,   // heading[16:0], pitch[33:17], roll[50:34], zero
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata    // m00, m10, m20, m01, m11, m21, m02, m12, m22
);
    import hpr_pkg::*;

    logic     en;
    angle3_t  angles;
    logic     ph_valid, sc_valid, mx_valid;
    phase3_t  phases;
    sincos3_t sc;
    matrix_t  m;

    assign en            = !mx_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign angles[0] = s_axis_tdata[16:0];
    assign angles[1] = s_axis_tdata[33:17];
    assign angles[2] = s_axis_tdata[50:34];

    hpr_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .angles    (angles),
        .out_valid (ph_valid),
        .phases    (phases)
    );

    hpr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ph_valid),
        .phases    (phases),
        .out_valid (sc_valid),
        .sc        (sc)
    );

    hpr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .sc        (sc),
        .out_valid (mx_valid),
        .m         (m)
    );

    assign m_axis_tvalid = mx_valid;
    assign m_axis_tdata  = m;

endmodule
`default_nettype wire

// ===== rtl/core/hpr_phase.sv =====
// angle reduction modulo one turn and scaling to a 32-bit phase, four stages
`timescale 1ns / 1ps
`default_nettype none
module hpr_phase (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  hpr_pkg::angle3_t angles,
    output logic                   out_valid,
    output hpr_pkg::phase3_t       phases
);
    import hpr_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [U_W-1:0]     u_reg [3];
    logic [U_W-1:0]     q_reg [3];
    logic [A_W-1:0]     a_reg [3];
    logic [A_W-1:0]     a3_reg [3];
    logic [K_W-1:0]     k_reg [3];
    phase3_t            ph_reg;

    logic [U_W-1:0]      u_next [3];
    logic [U_W-1:0]      q_next [3];
    logic [A_W-1:0]      a_next [3];
    logic [K_W-1:0]      k_next [3];
    phase3_t             ph_next;
    logic [U_W+RQ_W-1:0] qprod [3];
    logic [U_W:0]        diff [3];
    logic [A_W+RK_W-1:0] kprod [3];
    logic [R_W-1:0]      r [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            u_next[j] = U_W'(longint'(angles[j]) + ANG_OFS);
            qprod[j]  = (U_W+RQ_W)'(u_next[j]) * (U_W+RQ_W)'(RQ);
            q_next[j] = U_W'(qprod[j] >> RQS);
            // estimate is at most one low, so one correction
            diff[j]   = {1'b0, u_reg[j]} - (U_W+1)'(q_reg[j] * (U_W+1)'(ANG_MOD));
            if (diff[j] >= (U_W+1)'(ANG_MOD))
            begin
                a_next[j] = A_W'(diff[j] - (U_W+1)'(ANG_MOD));
            end
            else
            begin
                a_next[j] = A_W'(diff[j]);
            end
            kprod[j]   = (A_W+RK_W)'(a_reg[j]) * (A_W+RK_W)'(RK);
            k_next[j]  = K_W'(kprod[j] >> RKS);
            r[j]       = R_W'(a3_reg[j] - A_W'(k_reg[j] * A_W'(45)));
            ph_next[j] = {k_reg[j], FRAC_TAB[r[j]]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                u_reg[j]  <= u_next[j];
                q_reg[j]  <= q_next[j];
                a_reg[j]  <= a_next[j];
                a3_reg[j] <= a_reg[j];
                k_reg[j]  <= k_next[j];
            end
            ph_reg <= ph_next;
        end
    end

    assign out_valid = v4_reg;
    assign phases    = ph_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hpr_cordic.sv =====
// pipelined rotation cordic, one iteration per stage, three lanes
`timescale 1ns / 1ps
`default_nettype none
module hpr_cordic (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  hpr_pkg::phase3_t phases,
    output logic                   out_valid,
    output hpr_pkg::sincos3_t      sc
);
    import hpr_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    logic               vld_reg [N+2];
    logic signed [Q_W-1:0] x_reg [N+1][3];
    logic signed [Q_W-1:0] y_reg [N+1][3];
    logic signed [Q_W-1:0] z_reg [N+1][3];
    logic [1:0]            q_reg [N+1][3];
    sincos3_t              sc_reg;

    logic [1:0]            q0_next [3];
    logic [31:0]           d0_next [3];
    sincos3_t              sc_next;

    // fold to the nearest quarter turn
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            q0_next[j] = 2'((phases[j] + 32'h20000000) >> 30);
            d0_next[j] = phases[j] - {q0_next[j], 30'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                x_reg[0][j] <= GAIN_Q30;
                y_reg[0][j] <= '0;
                z_reg[0][j] <= $signed(d0_next[j]);
                q_reg[0][j] <= q0_next[j];
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [Q_W-1:0] x_next [3];
        logic signed [Q_W-1:0] y_next [3];
        logic signed [Q_W-1:0] z_next [3];

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!z_reg[i][j][Q_W-1])
                begin
                    x_next[j] = x_reg[i][j] - (y_reg[i][j] >>> i);
                    y_next[j] = y_reg[i][j] + (x_reg[i][j] >>> i);
                    z_next[j] = z_reg[i][j] - $signed(ATAN_TURNS[i]);
                end
                else
                begin
                    x_next[j] = x_reg[i][j] + (y_reg[i][j] >>> i);
                    y_next[j] = y_reg[i][j] - (x_reg[i][j] >>> i);
                    z_next[j] = z_reg[i][j] + $signed(ATAN_TURNS[i]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    x_reg[i+1][j] <= x_next[j];
                    y_reg[i+1][j] <= y_next[j];
                    z_reg[i+1][j] <= z_next[j];
                    q_reg[i+1][j] <= q_reg[i][j];
                end
            end
        end
    end

    // quadrant applied by swaps and negations
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            unique case (q_reg[N][j])
                2'd0:
                begin
                    sc_next[j].c = x_reg[N][j];
                    sc_next[j].s = y_reg[N][j];
                end
                2'd1:
                begin
                    sc_next[j].c = -y_reg[N][j];
                    sc_next[j].s = x_reg[N][j];
                end
                2'd2:
                begin
                    sc_next[j].c = -x_reg[N][j];
                    sc_next[j].s = -y_reg[N][j];
                end
                default:
                begin
                    sc_next[j].c = y_reg[N][j];
                    sc_next[j].s = -x_reg[N][j];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N + 2; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < N + 2; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[N+1];
    assign sc        = sc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hpr_matrix.sv =====
// products, sums and output rounding of the rotation matrix, three stages
`timescale 1ns / 1ps
`default_nettype none
module hpr_matrix (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire  hpr_pkg::sincos3_t sc,
    output logic                    out_valid,
    output hpr_pkg::matrix_t        m
);
    import hpr_pkg::*;

    localparam int     OUT_SH   = 30 - OUT_FRAC_BITS;
    localparam longint ROUND_C  = (longint'(1) << OUT_SH) >> 1;
    localparam longint ONE      = longint'(1) << OUT_FRAC_BITS;
    localparam longint LIM_HI   = (ONE > 32767) ? 32767 : ONE;
    localparam longint LIM_LO   = (-ONE < -32768) ? -32768 : -ONE;

    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    function automatic entry_t to_out(input logic signed [Q_W:0] v);
        logic signed [Q_W+1:0] t;
        t = ($signed({v[Q_W], v}) + (Q_W+2)'(ROUND_C)) >>> OUT_SH;
        if (t > (Q_W+2)'(LIM_HI))
        begin
            t = (Q_W+2)'(LIM_HI);
        end
        else if (t < (Q_W+2)'(LIM_LO))
        begin
            t = (Q_W+2)'(LIM_LO);
        end
        return t[OUT_W-1:0];
    endfunction

    logic    va_reg, vb_reg, vc_reg;
    q30_t    sh, ch, sp, cp, sr, cr;
    q30_t    srsp_reg, crsp_reg, srcp_reg, chcr_reg, shcp_reg, srch_reg;
    q30_t    crsh_reg, chcp_reg, srsh_reg, crcp_reg, sh_reg, ch_reg, sp_reg;
    q30_t    shsrsp_reg, srspch_reg, shcrsp_reg, crspch_reg;
    q30_t    chcr_b_reg, shcp_b_reg, srch_b_reg, crsh_b_reg, chcp_b_reg;
    q30_t    srsh_b_reg, crcp_b_reg, srcp_b_reg, sp_b_reg;
    matrix_t m_reg;
    matrix_t m_next;

    assign sh = sc[0].s;
    assign ch = sc[0].c;
    assign sp = sc[1].s;
    assign cp = sc[1].c;
    assign sr = sc[2].s;
    assign cr = sc[2].c;

    always_comb
    begin
        m_next[0] = to_out({chcr_b_reg[Q_W-1], chcr_b_reg} - {shsrsp_reg[Q_W-1], shsrsp_reg});
        m_next[1] = to_out(-{shcp_b_reg[Q_W-1], shcp_b_reg});
        m_next[2] = to_out({srch_b_reg[Q_W-1], srch_b_reg} + {shcrsp_reg[Q_W-1], shcrsp_reg});
        m_next[3] = to_out({crsh_b_reg[Q_W-1], crsh_b_reg} + {srspch_reg[Q_W-1], srspch_reg});
        m_next[4] = to_out({chcp_b_reg[Q_W-1], chcp_b_reg});
        m_next[5] = to_out({srsh_b_reg[Q_W-1], srsh_b_reg} - {crspch_reg[Q_W-1], crspch_reg});
        m_next[6] = to_out(-{srcp_b_reg[Q_W-1], srcp_b_reg});
        m_next[7] = to_out({sp_b_reg[Q_W-1], sp_b_reg});
        m_next[8] = to_out({crcp_b_reg[Q_W-1], crcp_b_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // first products
            srsp_reg <= mul_q30(sr, sp);
            crsp_reg <= mul_q30(cr, sp);
            srcp_reg <= mul_q30(sr, cp);
            chcr_reg <= mul_q30(ch, cr);
            shcp_reg <= mul_q30(sh, cp);
            srch_reg <= mul_q30(sr, ch);
            crsh_reg <= mul_q30(cr, sh);
            chcp_reg <= mul_q30(ch, cp);
            srsh_reg <= mul_q30(sr, sh);
            crcp_reg <= mul_q30(cr, cp);
            sh_reg   <= sh;
            ch_reg   <= ch;
            sp_reg   <= sp;
            // second products
            shsrsp_reg <= mul_q30(sh_reg, srsp_reg);
            srspch_reg <= mul_q30(srsp_reg, ch_reg);
            shcrsp_reg <= mul_q30(sh_reg, crsp_reg);
            crspch_reg <= mul_q30(crsp_reg, ch_reg);
            chcr_b_reg <= chcr_reg;
            shcp_b_reg <= shcp_reg;
            srch_b_reg <= srch_reg;
            crsh_b_reg <= crsh_reg;
            chcp_b_reg <= chcp_reg;
            srsh_b_reg <= srsh_reg;
            crcp_b_reg <= crcp_reg;
            srcp_b_reg <= srcp_reg;
            sp_b_reg   <= sp_reg;
            m_reg      <= m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign m         = m_reg;

endmodule
`default_nettype wire
